### rtl/sbpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared types and constants for the start-byte packet deframer.
// ----------------------------------------------------------------------------
package sbpd_pkg;

  // Number of payload bytes in one packet.
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

  // Start marker value after reset.
  localparam logic [7:0] MARKER_RESET = 8'h80;

  // Framing phase.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // One finished packet.
  typedef struct packed {
    logic [PAYLOAD_LEN-1:0][7:0] payload;
    logic                        ok;
  } result_t;

endpackage

### rtl/sbpd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_in_reg
// Input register: holds one received byte until the framing logic takes it.
// ----------------------------------------------------------------------------
module sbpd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic load;
  logic full;
  logic full_next;

  // The register frees up in the same cycle that its item is taken.
  assign in_stall = full && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end else begin
      full_next = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_data <= rx_byte;
    end
  end

  assign byte_valid = full;

  // A taken item must have been present.
  assert property (@(posedge clk) disable iff (rst) take |-> full)
    else $error("sbpd_in_reg: take without a held item");

endmodule

### rtl/sbpd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_frame
// Framing logic: marker hunt, payload capture, running sum and checksum test.
// ----------------------------------------------------------------------------
module sbpd_frame (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             byte_valid,
  input  logic [7:0]       byte_data,
  input  logic             out_busy,
  output logic             take,
  output logic             res_valid,
  output sbpd_pkg::result_t res
);

  import sbpd_pkg::*;

  phase_t                       phase;
  phase_t                       phase_next;
  logic [IDX_W-1:0]             idx;
  logic [IDX_W-1:0]             idx_next;
  logic [7:0]                   sum;
  logic [7:0]                   sum_next;
  logic [7:0]                   marker;
  logic [PAYLOAD_LEN-1:0][7:0]  store;
  logic                         store_we;

  // Start marker register.
  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MARKER_RESET;
    end else if (cfg_we) begin
      marker <= cfg_wdata;
    end
  end

  // A checksum item waits while the result register holds a stalled result.
  assign take = byte_valid && !((phase == PH_CHECK) && out_busy);

  // Next state and outputs.
  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    sum_next   = sum;
    store_we   = 1'b0;
    res_valid  = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (take && (byte_data == marker)) begin
          phase_next = PH_PAYLOAD;
          idx_next   = '0;
          sum_next   = '0;
        end
      end
      PH_PAYLOAD: begin
        if (take) begin
          store_we = 1'b1;
          sum_next = sum + byte_data;
          idx_next = idx + 1'b1;
          if (idx == IDX_W'(PAYLOAD_LEN - 1)) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (take) begin
          res_valid  = 1'b1;
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      idx   <= '0;
      sum   <= '0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
      sum   <= sum_next;
    end
  end

  // Payload bytes, one entry written per item.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[idx] <= byte_data;
    end
  end

  // The checksum matches the inverse of the wrapping payload sum.
  assign res.payload = store;
  assign res.ok      = (byte_data == ~sum);

  // A result only comes from the checksum phase.
  assert property (@(posedge clk) disable iff (rst) res_valid |-> (phase == PH_CHECK))
    else $error("sbpd_frame: result outside the checksum phase");

  // The checksum phase is entered only after the last payload byte.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD && phase_next == PH_CHECK) |-> (idx == IDX_W'(PAYLOAD_LEN - 1)))
    else $error("sbpd_frame: checksum phase entered early");

  // A marker seen while hunting starts a packet with a cleared sum.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT && take && byte_data == marker)
      |=> (phase == PH_PAYLOAD && idx == '0 && sum == '0))
    else $error("sbpd_frame: packet start not set up");

endmodule

### rtl/sbpd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_out_reg
// Result register: holds one finished packet until the receiver takes it.
// ----------------------------------------------------------------------------
module sbpd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  sbpd_pkg::result_t res,
  output logic              out_busy,
  output logic              out_valid,
  input  logic              out_stall,
  output sbpd_pkg::result_t held
);

  import sbpd_pkg::*;

  logic full;
  logic full_next;

  // The register is busy only while a held item is stalled.
  assign out_busy = full && out_stall;

  always_comb begin
    if (res_valid) begin
      full_next = 1'b1;
    end else if (full && !out_stall) begin
      full_next = 1'b0;
    end else begin
      full_next = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign out_valid = full;

  // A new result never overwrites one that is still stalled.
  assert property (@(posedge clk) disable iff (rst) res_valid |-> !out_busy)
    else $error("sbpd_out_reg: result lost");

  // A loaded result shows on the next cycle.
  assert property (@(posedge clk) disable iff (rst) res_valid |=> out_valid)
    else $error("sbpd_out_reg: loaded result not shown");

endmodule

### rtl/start_byte_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_byte_packet_deframer
// Hunts for a start marker, collects eight payload bytes and a checksum byte,
// and delivers the payload with a checksum flag.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   input    in_valid / in_stall    rx_byte
//   output   out_valid / out_stall  mode_byte .. gain_p2, checksum_ok
//   config   cfg_we                 cfg_wdata (start marker)
//
// One byte is accepted per cycle through the single input register, unless a
// checksum item waits on a stalled result. Taking the checksum item loads the
// result register, and the result leaves once out_stall is low. Reset returns
// to hunting with the marker at 0x80. While a result is stalled, payload bytes
// are still taken; only a checksum item waits in the input register.
// ----------------------------------------------------------------------------
module start_byte_packet_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] mode_byte,
  output logic [7:0] lift_byte,
  output logic [7:0] roll_byte,
  output logic [7:0] pitch_byte,
  output logic [7:0] yaw_byte,
  output logic [7:0] gain_p,
  output logic [7:0] gain_p1,
  output logic [7:0] gain_p2,
  output logic       checksum_ok
);

  import sbpd_pkg::*;

  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       out_busy;
  logic       res_valid;
  result_t    res;
  result_t    held;

  // Input byte register.
  sbpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Framing and checksum logic.
  sbpd_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .out_busy   (out_busy),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register.
  sbpd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_busy  (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  // Payload bytes in packet order.
  assign mode_byte   = held.payload[0];
  assign lift_byte   = held.payload[1];
  assign roll_byte   = held.payload[2];
  assign pitch_byte  = held.payload[3];
  assign yaw_byte    = held.payload[4];
  assign gain_p      = held.payload[5];
  assign gain_p1     = held.payload[6];
  assign gain_p2     = held.payload[7];
  assign checksum_ok = held.ok;

endmodule

### verif/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the link, configuration and result channels of the start-byte
// packet deframer. It predicts every packet from the accepted bytes and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  mode_byte,
  input  logic [7:0]  lift_byte,
  input  logic [7:0]  roll_byte,
  input  logic [7:0]  pitch_byte,
  input  logic [7:0]  yaw_byte,
  input  logic [7:0]  gain_p,
  input  logic [7:0]  gain_p1,
  input  logic [7:0]  gain_p2,
  input  logic        checksum_ok,
  output int unsigned errors,
  output int unsigned results_due
);

  import sbpd_pkg::*;

  string byte_names [PAYLOAD_LEN] = '{"mode_byte", "lift_byte", "roll_byte",
                                      "pitch_byte", "yaw_byte", "gain_p",
                                      "gain_p1", "gain_p2"};

  // Shadow of the framing state and of the start marker register.
  logic [7:0]                  marker;
  phase_t                      phase;
  int unsigned                 byte_idx;
  logic [PAYLOAD_LEN-1:0][7:0] frame;
  logic [7:0]                  frame_sum;
  result_t                     packets_due [$];

  task automatic flag_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    errors++;
    $display("%0t: %s expected %02h, got %02h", $time, what, want, got);
  endtask

  // Advances the shadow framer by one link byte and queues a packet when
  // the checksum byte arrives.
  task automatic take_link_byte(input logic [7:0] b);
    result_t pkt;
    case (phase)
      PH_PAYLOAD: begin
        frame[byte_idx] = b;
        frame_sum = frame_sum + b;
        if (byte_idx == PAYLOAD_LEN - 1) begin
          phase = PH_CHECK;
        end else begin
          byte_idx++;
        end
      end
      PH_CHECK: begin
        pkt.payload = frame;
        pkt.ok = (b == 8'(~frame_sum));
        packets_due.push_back(pkt);
        phase = PH_HUNT;
      end
      default: begin
        // A marker byte opens a packet; anything else is dropped.
        if (b == marker) begin
          phase = PH_PAYLOAD;
          byte_idx = 0;
          frame_sum = '0;
        end
      end
    endcase
  endtask

  // Compares one delivered packet with the oldest one predicted.
  task automatic check_packet();
    result_t    want;
    logic [7:0] got [PAYLOAD_LEN];
    got = '{mode_byte, lift_byte, roll_byte, pitch_byte, yaw_byte,
            gain_p, gain_p1, gain_p2};
    if (packets_due.size() == 0) begin
      errors++;
      $display("%0t: result expected none, got one with no packet pending", $time);
    end else begin
      want = packets_due.pop_front();
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
        if (got[k] !== want.payload[k]) begin
          flag_mismatch(byte_names[k], want.payload[k], got[k]);
        end
      end
      if (checksum_ok !== want.ok) begin
        flag_mismatch("checksum_ok", {7'b0, want.ok}, {7'b0, checksum_ok});
      end
    end
  endtask

  // Results are compared before new bytes are taken; a packet can never
  // leave on the edge that accepts its checksum byte.
  always @(posedge clk) begin
    if (rst) begin
      marker = MARKER_RESET;
      phase = PH_HUNT;
      byte_idx = 0;
      frame = '0;
      frame_sum = '0;
      errors = 0;
      packets_due.delete();
      results_due <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_packet();
      end
      if (in_valid && !in_stall) begin
        take_link_byte(rx_byte);
      end
      if (cfg_we) begin
        marker = cfg_wdata;
      end
      results_due <= packets_due.size();
    end
  end

endmodule

### verif/tb_start_byte_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_start_byte_packet_deframer
// Drives link bytes into the start-byte packet deframer: a short directed
// run of framing corner cases, then random packets (mostly well formed, some
// cut short, some with bad checksums) under several start markers. The
// sender idles in bursts and the receiver stalls on its own pattern; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_start_byte_packet_deframer;
  import sbpd_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 210;
  // Cycles allowed for the input register and the result pipeline to drain.
  localparam int unsigned SETTLE_CYCLES   = 8;

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_HOLD,
    SINK_JITTER
  } sink_style_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = MARKER_RESET;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  mode_byte, lift_byte, roll_byte, pitch_byte, yaw_byte;
  logic [7:0]  gain_p, gain_p1, gain_p2;
  logic        checksum_ok;
  int unsigned errors;
  int unsigned results_due;

  int unsigned burst_left = 0;
  bit          gapless    = 1'b0;
  int unsigned packet_items = 0;
  sink_style_t sink_style = SINK_OPEN;
  int unsigned sink_left  = 0;

  start_byte_packet_deframer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode_byte   (mode_byte),
    .lift_byte   (lift_byte),
    .roll_byte   (roll_byte),
    .pitch_byte  (pitch_byte),
    .yaw_byte    (yaw_byte),
    .gain_p      (gain_p),
    .gain_p1     (gain_p1),
    .gain_p2     (gain_p2),
    .checksum_ok (checksum_ok)
  );

  deframer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode_byte   (mode_byte),
    .lift_byte   (lift_byte),
    .roll_byte   (roll_byte),
    .pitch_byte  (pitch_byte),
    .yaw_byte    (yaw_byte),
    .gain_p      (gain_p),
    .gain_p1     (gain_p1),
    .gain_p2     (gain_p2),
    .checksum_ok (checksum_ok),
    .errors      (errors),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: open, held and jittery stretches of random length.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_style = sink_style_t'($urandom_range(0, 2));
      sink_left = (sink_style == SINK_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 48);
    end
    sink_left--;
    case (sink_style)
      SINK_OPEN: out_stall <= 1'b0;
      SINK_HOLD: out_stall <= 1'b1;
      default:   out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  // Offers one link byte and returns on the edge that accepts it. Bursts of
  // random length are separated by random gaps unless the sender runs flat.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(0, 7);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends a marker and the first cut bytes of the packet that follows it;
  // a cut of nine sends the whole packet. The checksum is the inverted
  // payload sum with bad_mask flipping bits of it.
  task automatic send_packet(input logic [7:0] marker,
                             input logic [PAYLOAD_LEN-1:0][7:0] body,
                             input logic [7:0] bad_mask, input int unsigned cut);
    logic [7:0] sum;
    sum = '0;
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      sum = sum + body[k];
    end
    send_byte(marker);
    for (int k = 0; k < PAYLOAD_LEN && k < cut; k++) begin
      send_byte(body[k]);
    end
    if (cut > PAYLOAD_LEN) begin
      send_byte(~sum ^ bad_mask);
    end
    packet_items += 1 + ((cut > PAYLOAD_LEN + 1) ? PAYLOAD_LEN + 1 : cut);
  endtask

  // Holds the link idle until every predicted packet has been delivered
  // and the pipeline has had time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random packets framed by the given marker. Payload bytes lean toward
  // the marker and the extremes; a few packets are cut short or carry a
  // damaged checksum, and short runs of noise sit between packets.
  task automatic random_phase(input logic [7:0] marker, input int unsigned n,
                              input bit flat);
    logic [PAYLOAD_LEN-1:0][7:0] body;
    logic [7:0]                  mask;
    logic [7:0]                  noise;
    int unsigned                 goal;
    gapless = flat;
    goal = packet_items + n;
    while (packet_items < goal) begin
      repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0) begin
        noise = 8'($urandom);
        send_byte((noise == marker) ? noise ^ 8'h01 : noise);
        packet_items++;
      end
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
        case ($urandom_range(0, 7))
          0:       body[k] = marker;
          1:       body[k] = 8'h00;
          2:       body[k] = 8'hFF;
          default: body[k] = 8'($urandom);
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1:    mask = 8'h01 << $urandom_range(0, 7);
        2:       mask = 8'($urandom);
        default: mask = 8'h00;
      endcase
      send_packet(marker, body, mask,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : PAYLOAD_LEN + 1);
    end
    gapless = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Noise while hunting is dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    // Marker bytes and extremes inside the payload, good checksum.
    send_packet(MARKER_RESET,
                {8'h7F, 8'h80, 8'hFE, 8'h01, 8'h80, 8'hFF, 8'h00, 8'h80}, 8'h00,
                PAYLOAD_LEN + 1);
    // All-ones payload; the damaged checksum equals the marker and is
    // still taken as the checksum byte.
    send_packet(MARKER_RESET, {PAYLOAD_LEN{8'hFF}}, 8'h87, PAYLOAD_LEN + 1);

    // Random traffic under several markers, extremes included.
    write_marker(8'h00);
    random_phase(8'h00, ITEMS_PER_PHASE, 1'b0);
    write_marker(8'hFF);
    random_phase(8'hFF, ITEMS_PER_PHASE, 1'b1);
    begin
      logic [7:0] pick;
      pick = 8'($urandom);
      write_marker(pick);
      random_phase(pick, ITEMS_PER_PHASE, 1'b0);
    end
    write_marker(8'h5A);
    random_phase(8'h5A, ITEMS_PER_PHASE, 1'b0);
    write_marker(MARKER_RESET);
    random_phase(MARKER_RESET, ITEMS_PER_PHASE, 1'b0);

    settle();
    if (errors == 0 && results_due == 0) begin
      $display("tb_start_byte_packet_deframer: done, clean");
    end else begin
      $display("tb_start_byte_packet_deframer: done, errors");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_start_byte_packet_deframer: done, errors");
    $finish;
  end

endmodule
